### src/tlcq_pkg.sv
// Shared types and codes for the timed LED command queue.
`default_nettype none

package tlcq_pkg;

    // Bounds on the single-key position of a command
    localparam int KEY_ROWS = 8;
    localparam int KEY_COLS = 32;

    // Operation codes of an input beat
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_ENQUEUE = 3'd1;
    localparam logic [2:0] OP_CANCEL  = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_DRAIN   = 3'd5;
    localparam logic [2:0] OP_ERROR   = 3'd6;

    // Status codes of a result beat
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // Playback run states
    localparam logic [1:0] RUN_IDLE    = 2'd0;
    localparam logic [1:0] RUN_ACTIVE  = 2'd1;
    localparam logic [1:0] RUN_STOPPED = 2'd2;

    // Id given to a command enqueued into an empty queue
    localparam logic [15:0] INITIAL_TAG = 16'd1;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_DEC,
        ALU_EQ
    } alu_op_t;

    typedef struct packed {
        logic [23:0] color;
        logic        kind;
        logic [2:0]  row;
        logic [4:0]  col;
        logic [31:0] hold;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic        instr_kind;
        logic [2:0]  key_row;
        logic [4:0]  key_column;
        logic [23:0] color;
        logic [31:0] duration_us;
        logic [15:0] cancel_id;
        logic [3:0]  error_code;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] assigned_id;
        logic        emit_valid;
        logic        emit_kind;
        logic [2:0]  emit_row;
        logic [4:0]  emit_column;
        logic [23:0] emit_color;
    } result_t;

endpackage

`default_nettype wire

### src/tlcq_alu.sv
// Shared 32-bit adder used for id increment, hold countdown and tag compare.
`default_nettype none

module tlcq_alu
(
    input  tlcq_pkg::alu_op_t op,
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output logic [31:0]       sum,
    output logic              zero
);

    logic [31:0] addend;
    logic        carry_in;

    always_comb
    begin
        case (op)
            tlcq_pkg::ALU_INC:
            begin
                addend   = '0;
                carry_in = 1'b1;
            end
            tlcq_pkg::ALU_DEC:
            begin
                addend   = '1;
                carry_in = 1'b0;
            end
            tlcq_pkg::ALU_EQ:
            begin
                // a - b: zero result means equal
                addend   = ~b;
                carry_in = 1'b1;
            end
            default:
            begin
                addend   = '0;
                carry_in = 1'b0;
            end
        endcase
    end

    assign sum  = a + addend + {31'd0, carry_in};
    assign zero = (sum == '0);

endmodule

`default_nettype wire

### src/tlcq_store.sv
// Entry memory of the command queue: one write port, one registered read port.
`default_nettype none

module tlcq_store
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  tlcq_pkg::entry_t      wdata,
    input  logic [AW-1:0]         raddr,
    output tlcq_pkg::entry_t      rdata
);

    tlcq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/timed_led_command_queue_unit.sv
// Top level of the timed LED command queue: sequencer, ring pointers and result register.
`default_nettype none

// Each input beat is one operation on a queue of up to QUEUE_DEPTH LED commands kept in a
// circular entry memory; every beat yields exactly one result beat. The block takes one beat
// at a time and holds in_stall high until its result is in the output register, which can
// still be waiting while the next beat is taken. Cost per beat comes from the single read
// port of the entry memory: an enqueue into a non-empty queue reads the tail's tag before it
// writes, and cancel walks the queue one entry at a time, a read and then a compare, to find
// the id and then moves each later entry up one place with a read and then a write. Removing
// the playing head is a pointer step and moves no data. Head playback (the emit fields) is
// evaluated at the end of every operation.
module timed_led_command_queue_unit
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic        instr_kind,
    input  logic [2:0]  key_row,
    input  logic [4:0]  key_column,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [31:0] duration_us,
    input  logic [15:0] cancel_id,
    input  logic [3:0]  error_code,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] assigned_id,
    output logic        emit_valid,
    output logic        emit_kind,
    output logic [2:0]  emit_row,
    output logic [4:0]  emit_column,
    output logic [7:0]  emit_red,
    output logic [7:0]  emit_green,
    output logic [7:0]  emit_blue,
    output logic [1:0]  run_state,
    output logic [3:0]  latched_error
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ENQ_RD,
        S_ENQ_WR,
        S_CAN_RD,
        S_CAN_CMP,
        S_SH_RD,
        S_SH_WR,
        S_ADV,
        S_ADV_LD,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    tlcq_pkg::item_t      item_reg, item_next;
    tlcq_pkg::result_t    res_reg, res_next;
    tlcq_pkg::result_t    out_res_reg, out_res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_run_reg, out_run_next;
    logic [3:0]           out_err_reg, out_err_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        head_reg, head_next;
    logic [CW-1:0]        cur_reg, cur_next;
    logic [31:0]          hold_left_reg, hold_left_next;
    logic                 playing_reg, playing_next;
    logic [1:0]           run_reg, run_next;
    logic                 stop_reg, stop_next;
    logic                 drain_reg, drain_next;
    logic [3:0]           err_reg, err_next;

    // Memory and shared unit hookup
    logic [CW-1:0]        lidx;
    logic [IW:0]          phys_sum;
    logic [IW-1:0]        phys;
    logic                 mem_we;
    tlcq_pkg::entry_t     mem_wdata;
    tlcq_pkg::entry_t     mem_rdata;
    tlcq_pkg::alu_op_t    alu_op;
    logic [31:0]          alu_a;
    logic [31:0]          alu_b;
    logic [31:0]          alu_sum;
    logic                 alu_zero;

    logic [CW:0]          cur_inc;
    logic [CW:0]          cur_inc2;
    logic [IW-1:0]        head_inc;
    logic [31:0]          hold_dec;
    logic [15:0]          new_id;
    logic                 key_out_of_range;

    tlcq_store
    #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IW)
    )
    u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (phys),
        .wdata (mem_wdata),
        .raddr (phys),
        .rdata (mem_rdata)
    );

    tlcq_alu u_alu
    (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .sum  (alu_sum),
        .zero (alu_zero)
    );

    // Logical queue position to ring slot
    always_comb
    begin
        phys_sum = {1'b0, head_reg} + {1'b0, lidx[IW-1:0]};
        if (phys_sum >= DEPTH_W)
        begin
            phys = IW'(phys_sum - DEPTH_W);
        end
        else
        begin
            phys = phys_sum[IW-1:0];
        end
    end

    assign cur_inc  = {1'b0, cur_reg} + (CW + 1)'(1);
    assign cur_inc2 = {1'b0, cur_reg} + (CW + 1)'(2);
    assign head_inc = ({1'b0, head_reg} == DEPTH_W - (IW + 1)'(1)) ? '0 : head_reg + IW'(1);
    assign hold_dec = (hold_left_reg != '0) ? alu_sum : '0;
    assign new_id   = (count_reg == '0) ? tlcq_pkg::INITIAL_TAG : alu_sum[15:0];
    assign key_out_of_range = (int'(item_reg.key_row) >= tlcq_pkg::KEY_ROWS) ||
                              (int'(item_reg.key_column) >= tlcq_pkg::KEY_COLS);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        out_run_next   = out_run_reg;
        out_err_next   = out_err_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        hold_left_next = hold_left_reg;
        playing_next   = playing_reg;
        run_next       = run_reg;
        stop_next      = stop_reg;
        drain_next     = drain_reg;
        err_next       = err_reg;

        lidx      = cur_reg;
        mem_we    = 1'b0;
        mem_wdata = mem_rdata;
        alu_op    = tlcq_pkg::ALU_INC;
        alu_a     = '0;
        alu_b     = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next.operation   = operation;
                    item_next.instr_kind  = instr_kind;
                    item_next.key_row     = key_row;
                    item_next.key_column  = key_column;
                    item_next.color       = {red, green, blue};
                    item_next.duration_us = duration_us;
                    item_next.cancel_id   = cancel_id;
                    item_next.error_code  = error_code;
                    res_next              = '0;
                    state_next            = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_ADV;
                alu_op     = tlcq_pkg::ALU_DEC;
                alu_a      = hold_left_reg;
                case (item_reg.operation)
                    tlcq_pkg::OP_START:
                    begin
                        if (run_reg == tlcq_pkg::RUN_IDLE)
                        begin
                            run_next = tlcq_pkg::RUN_ACTIVE;
                        end
                        else
                        begin
                            res_next.status = tlcq_pkg::ST_IGNORED;
                        end
                    end
                    tlcq_pkg::OP_ENQUEUE:
                    begin
                        if (count_reg == DEPTH_C)
                        begin
                            res_next.status = tlcq_pkg::ST_FULL;
                        end
                        else if (item_reg.instr_kind && key_out_of_range)
                        begin
                            res_next.status = tlcq_pkg::ST_IGNORED;
                        end
                        else if (count_reg != '0)
                        begin
                            state_next = S_ENQ_RD;
                        end
                        else
                        begin
                            state_next = S_ENQ_WR;
                        end
                    end
                    tlcq_pkg::OP_CANCEL:
                    begin
                        // The playing head is never a candidate
                        cur_next = CW'(playing_reg);
                        if (CW'(playing_reg) >= count_reg)
                        begin
                            res_next.status = tlcq_pkg::ST_IGNORED;
                        end
                        else
                        begin
                            state_next = S_CAN_RD;
                        end
                    end
                    tlcq_pkg::OP_TICK:
                    begin
                        if (run_reg == tlcq_pkg::RUN_ACTIVE && playing_reg)
                        begin
                            hold_left_next = hold_dec;
                            if (hold_dec == '0)
                            begin
                                // Drop the finished head
                                head_next    = head_inc;
                                count_next   = count_reg - CW'(1);
                                playing_next = 1'b0;
                            end
                        end
                    end
                    tlcq_pkg::OP_STOP:
                    begin
                        if (run_reg == tlcq_pkg::RUN_STOPPED)
                        begin
                            res_next.status = tlcq_pkg::ST_IGNORED;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    tlcq_pkg::OP_DRAIN:
                    begin
                        if (run_reg == tlcq_pkg::RUN_STOPPED)
                        begin
                            res_next.status = tlcq_pkg::ST_IGNORED;
                        end
                        else
                        begin
                            drain_next = 1'b1;
                        end
                    end
                    tlcq_pkg::OP_ERROR:
                    begin
                        if (item_reg.error_code == '0)
                        begin
                            res_next.status = tlcq_pkg::ST_IGNORED;
                        end
                        else
                        begin
                            if (err_reg == '0)
                            begin
                                err_next = item_reg.error_code;
                            end
                            if (run_reg == tlcq_pkg::RUN_ACTIVE)
                            begin
                                run_next     = tlcq_pkg::RUN_STOPPED;
                                playing_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        res_next.status = tlcq_pkg::ST_IGNORED;
                    end
                endcase
            end

            S_ENQ_RD:
            begin
                // Fetch the tail's tag
                lidx       = count_reg - CW'(1);
                state_next = S_ENQ_WR;
            end

            S_ENQ_WR:
            begin
                lidx            = count_reg;
                alu_op          = tlcq_pkg::ALU_INC;
                alu_a           = {16'd0, mem_rdata.tag};
                mem_we          = 1'b1;
                mem_wdata.color = item_reg.color;
                mem_wdata.kind  = item_reg.instr_kind;
                mem_wdata.row   = item_reg.instr_kind ? item_reg.key_row : '0;
                mem_wdata.col   = item_reg.instr_kind ? item_reg.key_column : '0;
                mem_wdata.hold  = item_reg.duration_us;
                mem_wdata.tag   = new_id;
                count_next      = count_reg + CW'(1);
                res_next.assigned_id = new_id;
                state_next      = S_ADV;
            end

            S_CAN_RD:
            begin
                lidx       = cur_reg;
                state_next = S_CAN_CMP;
            end

            S_CAN_CMP:
            begin
                alu_op = tlcq_pkg::ALU_EQ;
                alu_a  = {16'd0, mem_rdata.tag};
                alu_b  = {16'd0, item_reg.cancel_id};
                if (alu_zero)
                begin
                    if (cur_inc < {1'b0, count_reg})
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_ADV;
                    end
                end
                else
                begin
                    cur_next = cur_inc[CW-1:0];
                    if (cur_inc < {1'b0, count_reg})
                    begin
                        state_next = S_CAN_RD;
                    end
                    else
                    begin
                        res_next.status = tlcq_pkg::ST_IGNORED;
                        state_next      = S_ADV;
                    end
                end
            end

            S_SH_RD:
            begin
                lidx       = cur_inc[CW-1:0];
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                // Move the next entry up one place to close the gap
                lidx      = cur_reg;
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                cur_next  = cur_inc[CW-1:0];
                if (cur_inc2 < {1'b0, count_reg})
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_ADV;
                end
            end

            S_ADV:
            begin
                lidx       = '0;
                state_next = S_DONE;
                if (run_reg == tlcq_pkg::RUN_ACTIVE && !playing_reg)
                begin
                    if (stop_reg)
                    begin
                        run_next = tlcq_pkg::RUN_STOPPED;
                    end
                    else if (count_reg == '0)
                    begin
                        if (drain_reg)
                        begin
                            run_next = tlcq_pkg::RUN_STOPPED;
                        end
                    end
                    else
                    begin
                        state_next = S_ADV_LD;
                    end
                end
            end

            S_ADV_LD:
            begin
                res_next.emit_valid  = 1'b1;
                res_next.emit_kind   = mem_rdata.kind;
                res_next.emit_row    = mem_rdata.row;
                res_next.emit_column = mem_rdata.col;
                res_next.emit_color  = mem_rdata.color;
                hold_left_next       = mem_rdata.hold;
                playing_next         = 1'b1;
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_res_next   = res_reg;
                    out_run_next   = run_reg;
                    out_err_next   = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            res_reg       <= '0;
            out_res_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_run_reg   <= tlcq_pkg::RUN_IDLE;
            out_err_reg   <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            cur_reg       <= '0;
            hold_left_reg <= '0;
            playing_reg   <= 1'b0;
            run_reg       <= tlcq_pkg::RUN_IDLE;
            stop_reg      <= 1'b0;
            drain_reg     <= 1'b0;
            err_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
            out_res_reg   <= out_res_next;
            out_valid_reg <= out_valid_next;
            out_run_reg   <= out_run_next;
            out_err_reg   <= out_err_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            cur_reg       <= cur_next;
            hold_left_reg <= hold_left_next;
            playing_reg   <= playing_next;
            run_reg       <= run_next;
            stop_reg      <= stop_next;
            drain_reg     <= drain_next;
            err_reg       <= err_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign assigned_id   = out_res_reg.assigned_id;
    assign emit_valid    = out_res_reg.emit_valid;
    assign emit_kind     = out_res_reg.emit_kind;
    assign emit_row      = out_res_reg.emit_row;
    assign emit_column   = out_res_reg.emit_column;
    assign emit_red      = out_res_reg.emit_color[23:16];
    assign emit_green    = out_res_reg.emit_color[15:8];
    assign emit_blue     = out_res_reg.emit_color[7:0];
    assign run_state     = out_run_reg;
    assign latched_error = out_err_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");

    a_playing_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> (count_reg != '0))
        else $error("head playing with empty queue");

    a_playing_active: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> (run_reg == tlcq_pkg::RUN_ACTIVE))
        else $error("head playing while not active");

    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && emit_valid) |-> (run_state == tlcq_pkg::RUN_ACTIVE))
        else $error("command emitted outside active run");

    a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tlcq_pkg::ST_FULL) |-> (assigned_id == '0))
        else $error("id given on full queue");
`endif

endmodule

`default_nettype wire

### tb/sv/timed_led_command_queue_unit_test.sv
// Self-checking bench for the timed LED command queue unit: queued stimulus, predictor, checker.
`timescale 1ns / 100ps

module timed_led_command_queue_unit_test;

    localparam int         SLOT_LIMIT = 16;
    localparam logic [2:0] OP_UNUSED  = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] assigned_id;
        logic        emit_valid;
        logic        emit_kind;
        logic [2:0]  emit_row;
        logic [4:0]  emit_column;
        logic [23:0] emit_color;
        logic [1:0]  run_state;
        logic [3:0]  latched_error;
    } led_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = '0;
    logic        instr_kind = 1'b0;
    logic [2:0]  key_row = '0;
    logic [4:0]  key_column = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [31:0] duration_us = '0;
    logic [15:0] cancel_id = '0;
    logic [3:0]  error_code = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] assigned_id;
    logic        emit_valid;
    logic        emit_kind;
    logic [2:0]  emit_row;
    logic [4:0]  emit_column;
    logic [7:0]  emit_red;
    logic [7:0]  emit_green;
    logic [7:0]  emit_blue;
    logic [1:0]  run_state;
    logic [3:0]  latched_error;

    // Stimulus and expectation stores
    tlcq_pkg::item_t beat_backlog[$];
    tlcq_pkg::item_t beat_on_bus;
    led_result_t     results_due[$];
    int              mismatch_count = 0;
    bit              steady_stretch = 1'b0;

    // Predictor state
    tlcq_pkg::entry_t cmd_slots[$];
    logic [31:0]      hold_remaining = '0;
    bit               head_live = 1'b0;
    logic [1:0]       play_mode = tlcq_pkg::RUN_IDLE;
    bit               stop_pending = 1'b0;
    bit               drain_pending = 1'b0;
    logic [3:0]       error_latch = '0;

    timed_led_command_queue_unit #(.QUEUE_DEPTH(SLOT_LIMIT)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .instr_kind    (instr_kind),
        .key_row       (key_row),
        .key_column    (key_column),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .duration_us   (duration_us),
        .cancel_id     (cancel_id),
        .error_code    (error_code),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .assigned_id   (assigned_id),
        .emit_valid    (emit_valid),
        .emit_kind     (emit_kind),
        .emit_row      (emit_row),
        .emit_column   (emit_column),
        .emit_red      (emit_red),
        .emit_green    (emit_green),
        .emit_blue     (emit_blue),
        .run_state     (run_state),
        .latched_error (latched_error)
    );

    always #5 clk = ~clk;

    // Apply one accepted command to the predicted queue and return its result beat.
    function automatic led_result_t apply_led_command(input tlcq_pkg::item_t cmd);
        led_result_t      res;
        tlcq_pkg::entry_t slot;
        logic [15:0]      new_id;
        bit               found;
        int               k;
        res = '0;
        res.status = tlcq_pkg::ST_OK;
        case (cmd.operation)
            tlcq_pkg::OP_START:
                if (play_mode == tlcq_pkg::RUN_IDLE)
                    play_mode = tlcq_pkg::RUN_ACTIVE;
                else
                    res.status = tlcq_pkg::ST_IGNORED;
            tlcq_pkg::OP_ENQUEUE:
                if (cmd_slots.size() >= SLOT_LIMIT)
                    res.status = tlcq_pkg::ST_FULL;
                else if (cmd.instr_kind && (cmd.key_row >= tlcq_pkg::KEY_ROWS ||
                                            cmd.key_column >= tlcq_pkg::KEY_COLS))
                    res.status = tlcq_pkg::ST_IGNORED;
                else
                begin
                    new_id = tlcq_pkg::INITIAL_TAG;
                    if (cmd_slots.size() != 0)
                        new_id = cmd_slots[cmd_slots.size() - 1].tag + 16'd1;
                    slot.color = cmd.color;
                    slot.kind  = cmd.instr_kind;
                    slot.row   = cmd.instr_kind ? cmd.key_row : 3'd0;
                    slot.col   = cmd.instr_kind ? cmd.key_column : 5'd0;
                    slot.hold  = cmd.duration_us;
                    slot.tag   = new_id;
                    cmd_slots.push_back(slot);
                    res.assigned_id = new_id;
                end
            tlcq_pkg::OP_CANCEL:
            begin
                res.status = tlcq_pkg::ST_IGNORED;
                found = 1'b0;
                // skip the playing head
                for (k = head_live ? 1 : 0; k < cmd_slots.size() && !found; k++)
                    if (cmd_slots[k].tag == cmd.cancel_id)
                    begin
                        cmd_slots.delete(k);
                        res.status = tlcq_pkg::ST_OK;
                        found = 1'b1;
                    end
            end
            tlcq_pkg::OP_TICK:
                if (play_mode == tlcq_pkg::RUN_ACTIVE && head_live)
                begin
                    if (hold_remaining != 0)
                        hold_remaining--;
                    if (hold_remaining == 0)
                    begin
                        cmd_slots.delete(0);
                        head_live = 1'b0;
                    end
                end
            tlcq_pkg::OP_STOP:
                if (play_mode == tlcq_pkg::RUN_STOPPED)
                    res.status = tlcq_pkg::ST_IGNORED;
                else
                    stop_pending = 1'b1;
            tlcq_pkg::OP_DRAIN:
                if (play_mode == tlcq_pkg::RUN_STOPPED)
                    res.status = tlcq_pkg::ST_IGNORED;
                else
                    drain_pending = 1'b1;
            tlcq_pkg::OP_ERROR:
                if (cmd.error_code == 4'd0)
                    res.status = tlcq_pkg::ST_IGNORED;
                else
                begin
                    if (error_latch == 4'd0)
                        error_latch = cmd.error_code;
                    if (play_mode == tlcq_pkg::RUN_ACTIVE)
                    begin
                        play_mode = tlcq_pkg::RUN_STOPPED;
                        head_live = 1'b0;
                    end
                end
            default:
                res.status = tlcq_pkg::ST_IGNORED;
        endcase

        // advance playback at an entry boundary
        if (play_mode == tlcq_pkg::RUN_ACTIVE && !head_live)
        begin
            if (stop_pending)
                play_mode = tlcq_pkg::RUN_STOPPED;
            else if (cmd_slots.size() == 0)
            begin
                if (drain_pending)
                    play_mode = tlcq_pkg::RUN_STOPPED;
            end
            else
            begin
                head_live = 1'b1;
                hold_remaining = cmd_slots[0].hold;
                res.emit_valid  = 1'b1;
                res.emit_kind   = cmd_slots[0].kind;
                res.emit_row    = cmd_slots[0].row;
                res.emit_column = cmd_slots[0].col;
                res.emit_color  = cmd_slots[0].color;
            end
        end
        res.run_state = play_mode;
        res.latched_error = error_latch;
        return res;
    endfunction

    function automatic bit idle_roll();
        return !steady_stretch && ($urandom_range(99) < 14);
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_led_result();
        led_result_t want;
        if (results_due.size() == 0)
        begin
            $display("%0t: result beat with nothing expected, actual status %0h", $time, status);
            mismatch_count++;
            return;
        end
        want = results_due.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("assigned_id", 32'(want.assigned_id), 32'(assigned_id));
        compare_field("emit_valid", 32'(want.emit_valid), 32'(emit_valid));
        compare_field("emit_kind", 32'(want.emit_kind), 32'(emit_kind));
        compare_field("emit_row", 32'(want.emit_row), 32'(emit_row));
        compare_field("emit_column", 32'(want.emit_column), 32'(emit_column));
        compare_field("emit_red", 32'(want.emit_color[23:16]), 32'(emit_red));
        compare_field("emit_green", 32'(want.emit_color[15:8]), 32'(emit_green));
        compare_field("emit_blue", 32'(want.emit_color[7:0]), 32'(emit_blue));
        compare_field("run_state", 32'(want.run_state), 32'(run_state));
        compare_field("latched_error", 32'(want.latched_error), 32'(latched_error));
    endtask

    // Driver: predict each accepted beat, then present the next one unless idling.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                results_due.push_back(apply_led_command(beat_on_bus));
            if (!in_valid || !in_stall)
            begin
                if (beat_backlog.size() != 0 && !idle_roll())
                begin
                    beat_on_bus = beat_backlog.pop_front();
                    in_valid    <= 1'b1;
                    operation   <= beat_on_bus.operation;
                    instr_kind  <= beat_on_bus.instr_kind;
                    key_row     <= beat_on_bus.key_row;
                    key_column  <= beat_on_bus.key_column;
                    red         <= beat_on_bus.color[23:16];
                    green       <= beat_on_bus.color[15:8];
                    blue        <= beat_on_bus.color[7:0];
                    duration_us <= beat_on_bus.duration_us;
                    cancel_id   <= beat_on_bus.cancel_id;
                    error_code  <= beat_on_bus.error_code;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result beat, stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_led_result();
            out_stall <= idle_roll();
        end
    end

    function automatic tlcq_pkg::item_t random_beat(input logic [2:0] op);
        tlcq_pkg::item_t b;
        b.operation   = op;
        b.instr_kind  = 1'($urandom_range(1));
        b.key_row     = 3'($urandom_range(7));
        b.key_column  = 5'($urandom_range(31));
        b.color       = 24'($urandom);
        b.duration_us = $urandom;
        b.cancel_id   = 16'($urandom);
        b.error_code  = 4'($urandom_range(15));
        return b;
    endfunction

    function automatic logic [31:0] hold_pick();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 32'd0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(16, 4);
    endfunction

    // Mostly ids still queued, sometimes the head, sometimes anything.
    function automatic logic [15:0] cancel_target();
        int n;
        int r;
        n = cmd_slots.size();
        r = $urandom_range(9);
        if (n != 0 && r < 6)
            return cmd_slots[$urandom_range(n - 1)].tag;
        if (n != 0 && r < 8)
            return cmd_slots[0].tag;
        return 16'($urandom);
    endfunction

    task automatic send_beat(input tlcq_pkg::item_t b);
        while (beat_backlog.size() != 0)
            @(negedge clk);
        beat_backlog.push_back(b);
    endtask

    task automatic send_op(input logic [2:0] op);
        send_beat(random_beat(op));
    endtask

    task automatic send_enqueue(input logic kind, input logic [2:0] row, input logic [4:0] col,
                                input logic [23:0] colour, input logic [31:0] hold);
        tlcq_pkg::item_t b;
        b = random_beat(tlcq_pkg::OP_ENQUEUE);
        b.instr_kind  = kind;
        b.key_row     = row;
        b.key_column  = col;
        b.color       = colour;
        b.duration_us = hold;
        send_beat(b);
    endtask

    task automatic send_random_enqueue(input logic [31:0] hold);
        send_enqueue(1'($urandom_range(1)), 3'($urandom_range(7)), 5'($urandom_range(31)),
                     24'($urandom), hold);
    endtask

    task automatic send_cancel(input logic [15:0] id);
        tlcq_pkg::item_t b;
        b = random_beat(tlcq_pkg::OP_CANCEL);
        b.cancel_id = id;
        send_beat(b);
    endtask

    task automatic send_error(input logic [3:0] code);
        tlcq_pkg::item_t b;
        b = random_beat(tlcq_pkg::OP_ERROR);
        b.error_code = code;
        send_beat(b);
    endtask

    // Hold the sender until every expected result has arrived.
    task automatic settle();
        while (beat_backlog.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int i;
        int pick;
        int ending;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: commands before start, start, head protection, zero duration
        send_op(tlcq_pkg::OP_TICK);
        send_error(4'd0);
        send_error(4'hA);
        send_op(OP_UNUSED);
        send_enqueue(1'b0, 3'd7, 5'd31, 24'hFFFFFF, 32'd0);
        send_enqueue(1'b1, 3'd7, 5'd31, 24'h000000, 32'd2);
        send_enqueue(1'b1, 3'd0, 5'd0, 24'h5A3CC3, 32'd1);
        send_cancel(16'd3);
        send_cancel(16'd0);
        send_cancel(16'hFFFF);
        send_op(tlcq_pkg::OP_START);
        send_op(tlcq_pkg::OP_START);
        send_cancel(16'd1);
        send_op(tlcq_pkg::OP_TICK);
        send_enqueue(1'b0, 3'd0, 5'd0, 24'h123456, 32'd1);
        repeat (4) send_op(tlcq_pkg::OP_TICK);

        // Random traffic while playback runs, with bursts that overflow the queue
        for (i = 0; i < 1050; i++)
        begin
            if (i == 525)
                settle();
            if (i % 160 == 80)
                repeat (18) send_random_enqueue(hold_pick());
            pick = $urandom_range(99);
            if (pick < 25)
                send_random_enqueue(hold_pick());
            else if (pick < 75)
                send_op(tlcq_pkg::OP_TICK);
            else if (pick < 88)
                send_cancel(cancel_target());
            else if (pick < 92)
                send_op(tlcq_pkg::OP_START);
            else if (pick < 96)
                send_error(4'd0);
            else
                send_op(OP_UNUSED);
        end

        // Keep the queue busy with no idling on either side
        steady_stretch = 1'b1;
        repeat (2) send_random_enqueue(32'd0);
        repeat (60)
        begin
            send_random_enqueue(32'd0);
            send_op(tlcq_pkg::OP_TICK);
        end
        steady_stretch = 1'b0;

        // End playback one of three ways
        ending = $urandom_range(2);
        case (ending)
            0:
            begin
                while (cmd_slots.size() != 0)
                    send_op(tlcq_pkg::OP_TICK);
                settle();
                send_random_enqueue(32'hFFFF_FFFF);
                repeat (3) send_op(tlcq_pkg::OP_TICK);
                send_op(tlcq_pkg::OP_STOP);
                send_error(4'h3);
            end
            1:
            begin
                repeat (3) send_random_enqueue(hold_pick());
                send_op(tlcq_pkg::OP_STOP);
                while (play_mode != tlcq_pkg::RUN_STOPPED)
                    send_op(tlcq_pkg::OP_TICK);
            end
            default:
            begin
                repeat (3) send_random_enqueue(hold_pick());
                send_op(tlcq_pkg::OP_DRAIN);
                while (play_mode != tlcq_pkg::RUN_STOPPED)
                    send_op(tlcq_pkg::OP_TICK);
            end
        endcase

        // Stopped: requests ignored, queue still fills and cancels
        settle();
        send_op(tlcq_pkg::OP_STOP);
        send_op(tlcq_pkg::OP_DRAIN);
        send_op(tlcq_pkg::OP_START);
        send_op(tlcq_pkg::OP_TICK);
        send_error(4'h9);
        repeat (18) send_random_enqueue(hold_pick());
        settle();
        send_cancel(cmd_slots[0].tag);
        for (i = 0; i < 80; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_cancel(cancel_target());
            else if (pick < 75)
                send_random_enqueue(hold_pick());
            else
                send_op(3'($urandom_range(7)));
        end

        settle();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
